@@ rtl/ipv4th_pkg.sv @@
// ipv4th_pkg: types, constants and helper functions for the IPv4 transport header parser.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ipv4th_pkg;

    // Frame byte counter saturates here
    localparam int MAX_FRAME_BYTES = 16384;
    localparam int IDX_W           = $clog2(MAX_FRAME_BYTES + 1);

    localparam logic [3:0] MIN_HDR_WORDS = 4'd5;
    localparam logic [3:0] IP_VERSION_4  = 4'd4;
    localparam logic [3:0] UDP_HDR_BYTES = 4'd8;

    localparam logic [7:0] PROTO_ICMP = 8'd1;
    localparam logic [7:0] PROTO_TCP  = 8'd6;
    localparam logic [7:0] PROTO_UDP  = 8'd17;

    // Configuration register indexes
    localparam logic [1:0] CFG_IP_OFFSET        = 2'd0;
    localparam logic [1:0] CFG_COPY_SRC_ADDR    = 2'd1;
    localparam logic [1:0] CFG_COPY_DST_ADDR    = 2'd2;
    localparam logic [1:0] CFG_DECODE_TRANSPORT = 2'd3;

    localparam logic [5:0] IP_OFFSET_RESET = 6'd14;

    typedef struct packed {
        logic [5:0] ip_offset;
        logic       copy_src_addr;
        logic       copy_dst_addr;
        logic       decode_transport;
    } cfg_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic        ok;
        logic [3:0]  ip_version;
        logic [7:0]  proto_number;
        logic [7:0]  time_to_live;
        logic [7:0]  type_of_service;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [31:0] icmp_info;
        logic [14:0] payload_offset;
        logic [15:0] payload_size;
    } out_item_t;

    // Header fields gathered while a frame streams in
    typedef struct packed {
        logic [3:0]  version;
        logic [3:0]  header_words;
        logic [7:0]  tos;
        logic [7:0]  ttl;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] port_pair;
        logic [15:0] udp_length;
        logic [3:0]  tcp_data_words;
        logic [31:0] icmp;
    } hdr_fields_t;

    // Everything the result stage needs at frame end
    typedef struct packed {
        hdr_fields_t            fields;
        logic [IDX_W-1:0]       frame_len;
    } frame_snap_t;

    // Header length in bytes from a word count, short headers taken as five words
    function automatic logic [5:0] hdr_bytes(input logic [3:0] words);
        logic [3:0] w;
        w = (words < MIN_HDR_WORDS) ? MIN_HDR_WORDS : words;
        return {w, 2'b00};
    endfunction

endpackage

@@ rtl/ipv4th_capture.sv @@
// ipv4th_capture: per-byte header field capture and frame-end snapshot register.
// Depends on ipv4th_pkg.
`timescale 1ns / 1ps

module ipv4th_capture
    import ipv4th_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_item_t    s_data,
    output logic        snap_valid,
    input  logic        snap_ready,
    output frame_snap_t snap
);

    logic [IDX_W-1:0] byte_idx_reg, byte_idx_next;
    hdr_fields_t      fields_reg, fields_next, fields_cap;
    logic             snap_valid_reg, snap_valid_next;
    frame_snap_t      snap_reg, snap_next;

    logic             s_fire;
    logic             in_ip, in_xport;
    logic [IDX_W-1:0] rel, xrel, ip_off_ext, hl_ext;
    logic [7:0]       b;

    assign s_ready = !snap_valid_reg || snap_ready;
    assign s_fire  = s_valid && s_ready;
    assign b       = s_data.data_byte;

    // Position relative to the IP header and to the transport header
    assign ip_off_ext = IDX_W'(cfg.ip_offset);
    assign hl_ext     = IDX_W'(hdr_bytes(fields_reg.header_words));
    assign in_ip      = byte_idx_reg >= ip_off_ext;
    assign rel        = byte_idx_reg - ip_off_ext;
    assign in_xport   = in_ip && (rel >= hl_ext);
    assign xrel       = rel - hl_ext;

    // Capture the fields that this byte carries
    always_comb begin
        fields_cap = fields_reg;
        if (in_ip) begin
            if (rel == IDX_W'(0)) begin
                fields_cap.version      = b[7:4];
                fields_cap.header_words = b[3:0];
            end else if (rel == IDX_W'(1)) begin
                fields_cap.tos = b;
            end else if (rel == IDX_W'(8)) begin
                fields_cap.ttl = b;
            end else if (rel == IDX_W'(9)) begin
                fields_cap.proto = b;
            end else if (rel >= IDX_W'(12) && rel <= IDX_W'(15)) begin
                fields_cap.src = {fields_reg.src[23:0], b};
            end else if (rel >= IDX_W'(16) && rel <= IDX_W'(19)) begin
                fields_cap.dst = {fields_reg.dst[23:0], b};
            end
        end
        if (in_xport) begin
            if (fields_reg.proto == PROTO_UDP || fields_reg.proto == PROTO_TCP) begin
                if (xrel <= IDX_W'(3)) begin
                    fields_cap.port_pair = {fields_reg.port_pair[23:0], b};
                end else if (fields_reg.proto == PROTO_UDP
                             && (xrel == IDX_W'(4) || xrel == IDX_W'(5))) begin
                    fields_cap.udp_length = {fields_reg.udp_length[7:0], b};
                end else if (fields_reg.proto == PROTO_TCP && xrel == IDX_W'(12)) begin
                    fields_cap.tcp_data_words = b[7:4];
                end
            end else if (fields_reg.proto == PROTO_ICMP) begin
                if (xrel == IDX_W'(0)) begin
                    fields_cap.icmp[31:24] = b;
                end else if (xrel == IDX_W'(1)) begin
                    fields_cap.icmp[23:16] = b;
                end else if (xrel == IDX_W'(6)) begin
                    fields_cap.icmp[15:8] = b;
                end else if (xrel == IDX_W'(7)) begin
                    fields_cap.icmp[7:0] = b;
                end
            end
        end
    end

    // Advance the byte count, clear on the last byte and take a snapshot
    always_comb begin
        fields_next     = fields_reg;
        byte_idx_next   = byte_idx_reg;
        snap_next       = snap_reg;
        snap_valid_next = snap_valid_reg;
        if (snap_ready) begin
            snap_valid_next = 1'b0;
        end
        if (s_fire) begin
            if (s_data.last) begin
                fields_next     = '0;
                byte_idx_next   = '0;
                snap_valid_next = 1'b1;
                snap_next.fields    = fields_cap;
                snap_next.frame_len = (byte_idx_reg < IDX_W'(MAX_FRAME_BYTES))
                                      ? byte_idx_reg + IDX_W'(1)
                                      : IDX_W'(MAX_FRAME_BYTES);
            end else begin
                fields_next = fields_cap;
                if (byte_idx_reg < IDX_W'(MAX_FRAME_BYTES)) begin
                    byte_idx_next = byte_idx_reg + IDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_idx_reg   <= '0;
            fields_reg     <= '0;
            snap_valid_reg <= 1'b0;
        end else begin
            byte_idx_reg   <= byte_idx_next;
            fields_reg     <= fields_next;
            snap_valid_reg <= snap_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        snap_reg <= snap_next;
    end

    assign snap_valid = snap_valid_reg;
    assign snap       = snap_reg;

    // A last-byte transfer restarts the count and raises the snapshot
    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.last) |=> (byte_idx_reg == '0 && snap_valid_reg))
        else $error("frame state not cleared after last byte");

    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        byte_idx_reg <= IDX_W'(MAX_FRAME_BYTES))
        else $error("byte count beyond frame limit");

    a_snap_len: assert property (@(posedge aclk) disable iff (!aresetn)
        snap_valid_reg |-> (snap_reg.frame_len != '0))
        else $error("snapshot holds an empty frame");

endmodule

@@ rtl/ipv4th_result.sv @@
// ipv4th_result: frame-end checks, payload arithmetic and the result register.
// Depends on ipv4th_pkg.
`timescale 1ns / 1ps

module ipv4th_result
    import ipv4th_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cfg_t        cfg,
    input  logic        snap_valid,
    output logic        snap_ready,
    input  frame_snap_t snap,
    output logic        m_valid,
    input  logic        m_ready,
    output out_item_t   m_data
);

    logic      m_valid_reg, m_valid_next;
    out_item_t m_data_reg, m_data_next;

    hdr_fields_t      f;
    logic [5:0]       ip_hb, tcp_hb;
    logic [7:0]       off, need, off_final;
    logic [15:0]      size_def, udp_size;
    logic             is_udp, is_tcp, is_icmp, ok;

    assign snap_ready = !m_valid_reg || m_ready;
    assign f          = snap.fields;

    // Header lengths and the bytes the frame must reach
    always_comb begin
        ip_hb   = hdr_bytes(f.header_words);
        tcp_hb  = hdr_bytes(f.tcp_data_words);
        is_udp  = cfg.decode_transport && f.proto == PROTO_UDP;
        is_tcp  = cfg.decode_transport && f.proto == PROTO_TCP;
        is_icmp = cfg.decode_transport && f.proto == PROTO_ICMP;
        off     = {2'b00, cfg.ip_offset} + {2'b00, ip_hb};
        need    = off;
        if (is_udp || is_icmp) begin
            need = off + {4'b0000, UDP_HDR_BYTES};
        end else if (is_tcp) begin
            need = off + {2'b00, tcp_hb};
        end
        ok       = f.version == IP_VERSION_4 && snap.frame_len >= IDX_W'(need);
        size_def = 16'(snap.frame_len) - {8'h00, off};
        udp_size = (f.udp_length >= 16'(UDP_HDR_BYTES))
                   ? f.udp_length - 16'(UDP_HDR_BYTES) : 16'h0000;
    end

    // Build the result item
    always_comb begin
        m_data_next                 = '0;
        m_data_next.ip_version      = f.version;
        m_data_next.proto_number    = f.proto;
        m_data_next.time_to_live    = f.ttl;
        m_data_next.type_of_service = f.tos;
        off_final                   = off;
        if (ok) begin
            m_data_next.ok           = 1'b1;
            m_data_next.src_addr     = cfg.copy_src_addr ? f.src : 32'h0;
            m_data_next.dst_addr     = cfg.copy_dst_addr ? f.dst : 32'h0;
            m_data_next.payload_size = size_def;
            if (is_udp || is_tcp) begin
                m_data_next.src_port = f.port_pair[31:16];
                m_data_next.dst_port = f.port_pair[15:0];
            end
            if (is_udp) begin
                off_final                = off + {4'b0000, UDP_HDR_BYTES};
                m_data_next.payload_size = udp_size;
            end else if (is_tcp) begin
                // frame length already covers the TCP header here
                off_final                = off + {2'b00, tcp_hb};
                m_data_next.payload_size = size_def - {10'b0, tcp_hb};
            end else if (is_icmp) begin
                m_data_next.icmp_info = f.icmp;
            end
            m_data_next.payload_offset = 15'(off_final);
        end
    end

    // Hold the result until the transfer completes
    always_comb begin
        m_valid_next = m_valid_reg;
        if (snap_ready) begin
            m_valid_next = snap_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (snap_ready && snap_valid) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_snap_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (snap_valid && snap_ready) |=> m_valid_reg)
        else $error("snapshot taken but no result raised");

    a_ok_version: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.ok) |-> (m_data_reg.ip_version == IP_VERSION_4))
        else $error("ok result without version four");

    a_not_ok_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_data_reg.ok)
        |-> (m_data_reg.payload_offset == '0 && m_data_reg.payload_size == '0
             && m_data_reg.src_port == '0 && m_data_reg.icmp_info == '0))
        else $error("failed frame carries payload fields");

endmodule

@@ rtl/ipv4_transport_header_parser_top.sv @@
// ipv4_transport_header_parser_top: configuration registers and the two pipeline stages.
// Depends on ipv4th_pkg, ipv4th_capture and ipv4th_result.
//
// Usage:
//   Input channel (s_valid/s_ready/s_data) carries one frame byte per transfer in wire
//   order, with s_data.last set on the final byte. Output channel (m_valid/m_ready/
//   m_data) carries one result per frame. The configuration port writes register
//   cfg_addr with cfg_wdata when cfg_wr_en is high; write only while no frame is in
//   progress and no result is pending.
//   Throughput: one byte per cycle while s_ready is high; a new frame may start the cycle after a last byte.
//   Result path: a last-byte transfer fills the snapshot register, then the result register,
//   which drives m_valid; the field capture registers each byte's fields as it is accepted.
//   Stall: a held result keeps s_ready high until the next frame end fills the snapshot
//   stage; with both stages full s_ready stays low until the result is taken.
//   Reset (aresetn low, synchronous): clears the byte count, captured fields and both
//   valid flags, and sets ip_offset to 14 and the three enables to 1.
`timescale 1ns / 1ps

module ipv4_transport_header_parser_top
    import ipv4th_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [1:0] cfg_addr,
    input  logic [5:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    cfg_t        cfg_reg, cfg_next;
    logic        snap_valid, snap_ready;
    frame_snap_t snap;

    // Decode configuration writes
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_IP_OFFSET:        cfg_next.ip_offset        = cfg_wdata;
                CFG_COPY_SRC_ADDR:    cfg_next.copy_src_addr    = cfg_wdata[0];
                CFG_COPY_DST_ADDR:    cfg_next.copy_dst_addr    = cfg_wdata[0];
                CFG_DECODE_TRANSPORT: cfg_next.decode_transport = cfg_wdata[0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ip_offset        <= IP_OFFSET_RESET;
            cfg_reg.copy_src_addr    <= 1'b1;
            cfg_reg.copy_dst_addr    <= 1'b1;
            cfg_reg.decode_transport <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    ipv4th_capture u_capture (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap)
    );

    ipv4th_result u_result (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .snap_valid (snap_valid),
        .snap_ready (snap_ready),
        .snap       (snap),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
